// File: hdl/o2pc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// o2pc_pkg
// Shared types and constants of the order-2 predictor codec.
// ----------------------------------------------------------------------------
package o2pc_pkg;

    // prediction table geometry
    localparam int TABLE_INDEX_BITS = 16;
    localparam int TABLE_DEPTH      = 1 << TABLE_INDEX_BITS;
    localparam logic [TABLE_INDEX_BITS-1:0] CLR_LAST = '1;

    // one group of plain bytes per mask byte
    localparam int GROUP_LEN = 8;

    // mode register codes
    localparam logic MODE_COMPRESS   = 1'b0;
    localparam logic MODE_DECOMPRESS = 1'b1;

    typedef logic [TABLE_INDEX_BITS-1:0] tbl_addr_t;
    typedef logic [GROUP_LEN-1:0][7:0]   lit_bank_t;

    // control states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_DRUN
    } state_t;

endpackage
`default_nettype wire

// File: hdl/order2_predictor_codec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// order2_predictor_codec
// Byte-stream codec with an order-2 predictor table (64K x 8 block memory).
//
// Channels: input requests (data_byte, restart, last_byte) and result requests
// (out_byte, is_mask, run_end) use valid/ready. The user must write mode
// through cfg_we/cfg_wdata only while the block is idle, which the block does
// not enforce; a write also resets the group. Compress: one plain byte per
// cycle. The table read is issued when a byte is taken and checked in the next
// cycle, where a miss writes the table back; a write to the address read in
// the same cycle is bypassed inside the memory. The eighth byte of a group
// hands mask and literals to a drain stage, which sends the mask, then the
// literals, one per cycle while the receiver takes them. Input also stalls
// when a group completes while the previous one is still draining. Decompress:
// a mask byte is not shown; a literal is written to the table and shown on the
// result register in the cycle after it is taken. Each predicted byte that
// follows costs one table read, one per cycle while the receiver takes them.
// Reset, and any request with restart set, run a clearing pass over all 65536
// entries before any request is taken; results already queued keep draining.
// A stalled receiver holds the result, the drain stage and a decompress run.
// ----------------------------------------------------------------------------
module order2_predictor_codec
(
    input  wire        clk,
    input  wire        rst_n,
    // configuration
    input  wire        cfg_we,
    input  wire        cfg_wdata,
    // input requests
    input  wire        in_valid,
    output logic       in_ready,
    input  wire  [7:0] data_byte,
    input  wire        restart,
    input  wire        last_byte,
    // result requests
    output logic       out_valid,
    input  wire        out_ready,
    output logic [7:0] out_byte,
    output logic       is_mask,
    output logic       run_end
);

    // table memory
    logic [7:0]           pred_mem [o2pc_pkg::TABLE_DEPTH];
    logic [7:0]           ram_q_reg;
    logic                 ram_re;
    logic                 ram_we;
    o2pc_pkg::tbl_addr_t  ram_raddr;
    o2pc_pkg::tbl_addr_t  ram_waddr;
    logic [7:0]           ram_wdata;

    // control state
    o2pc_pkg::state_t     state_reg, state_next;
    o2pc_pkg::tbl_addr_t  clr_cnt_reg, clr_cnt_next;
    logic                 restart_done_reg, restart_done_next;
    logic                 mode_reg, mode_next;

    // context and group state
    logic [7:0]           ctx_old_reg, ctx_old_next;
    logic [7:0]           ctx_new_reg, ctx_new_next;
    logic [3:0]           gp_reg, gp_next;
    logic [7:0]           mask_reg, mask_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic                 awaiting_reg, awaiting_next;
    o2pc_pkg::lit_bank_t  lit_q_reg, lit_q_next;
    logic                 d_last_reg, d_last_next;

    // compress check stage
    logic                 s1_valid_reg, s1_valid_next;
    logic [7:0]           s1_byte_reg, s1_byte_next;
    o2pc_pkg::tbl_addr_t  s1_addr_reg, s1_addr_next;
    logic                 s1_restart_reg, s1_restart_next;
    logic                 s1_last_reg, s1_last_next;

    // drain stage for mask and literals
    logic                 em_busy_reg, em_busy_next;
    logic [7:0]           em_mask_reg, em_mask_next;
    o2pc_pkg::lit_bank_t  em_lit_reg, em_lit_next;
    logic [3:0]           em_cnt_reg, em_cnt_next;
    logic [3:0]           em_idx_reg, em_idx_next;
    logic [2:0]           em_sel;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 out_mask_reg, out_mask_next;
    logic                 out_end_reg, out_end_next;
    logic                 out_load;
    logic                 out_load_ok;

    // compress check stage terms
    logic [3:0]           c_gp, c_gp_after, c_grp_gp, grp_gp_eff;
    logic [7:0]           c_mask, c_mask_after;
    logic [3:0]           c_cnt, c_cnt_after;
    logic                 c_hit, c_done;
    o2pc_pkg::lit_bank_t  c_lit_after;

    // decompress request terms
    logic [3:0]           d_base_gp, d_acc_gp, d_run_gp;
    logic [7:0]           d_base_mask, d_acc_mask;
    logic [7:0]           d_base_old, d_base_new, d_acc_old, d_acc_new;
    logic                 d_is_mask, d_acc_hit, d_run_hit;

    // handshake terms
    logic                 in_fire, in_ok, cand_done, em_free_next, clear_start;

    assign out_load_ok = !out_valid_reg || out_ready;
    assign in_fire     = in_valid && in_ready;
    assign em_sel      = em_idx_reg[2:0] - 3'd1;

    // compress check of the byte whose table read returned
    always_comb
    begin
        c_gp         = s1_restart_reg ? 4'd0 : gp_reg;
        c_mask       = s1_restart_reg ? 8'd0 : mask_reg;
        c_cnt        = s1_restart_reg ? 4'd0 : cnt_reg;
        c_hit        = (ram_q_reg == s1_byte_reg);
        c_mask_after = c_hit ? (c_mask | (8'd1 << c_gp[2:0])) : c_mask;
        c_cnt_after  = c_hit ? c_cnt : c_cnt + 4'd1;
        c_lit_after  = lit_q_reg;
        if (!c_hit)
        begin
            c_lit_after[c_cnt[2:0]] = s1_byte_reg;
        end
        c_gp_after   = c_gp + 4'd1;
        c_done       = c_gp_after[3];
        c_grp_gp     = (c_done || s1_last_reg) ? 4'd0 : c_gp_after;
        grp_gp_eff   = s1_valid_reg ? c_grp_gp : gp_reg;
    end

    // decompress terms for a new request and for a predicted byte
    always_comb
    begin
        d_is_mask   = restart || awaiting_reg;
        d_base_gp   = restart ? 4'd0 : gp_reg;
        d_base_mask = restart ? 8'd0 : mask_reg;
        d_base_old  = restart ? 8'd0 : ctx_old_reg;
        d_base_new  = restart ? 8'd0 : ctx_new_reg;
        d_acc_gp    = d_is_mask ? 4'd0 : d_base_gp + 4'd1;
        d_acc_mask  = d_is_mask ? data_byte : d_base_mask;
        d_acc_hit   = !d_acc_gp[3] && d_acc_mask[d_acc_gp[2:0]];
        d_acc_old   = d_is_mask ? d_base_old : d_base_new;
        d_acc_new   = d_is_mask ? d_base_new : data_byte;
        d_run_gp    = gp_reg + 4'd1;
        d_run_hit   = !d_run_gp[3] && mask_reg[d_run_gp[2:0]];
    end

    // input ready and clearing pass start
    always_comb
    begin
        in_ok        = (state_reg == o2pc_pkg::ST_RUN) && (!restart || restart_done_reg);
        cand_done    = !restart && (grp_gp_eff == 4'd7);
        em_free_next = !em_busy_reg || (out_load_ok && (em_idx_reg == em_cnt_reg));
        if (mode_reg == o2pc_pkg::MODE_COMPRESS)
        begin
            in_ready = in_ok && (!cand_done || em_free_next);
        end
        else
        begin
            in_ready = in_ok && (d_is_mask || out_load_ok);
        end
        clear_start = (state_reg == o2pc_pkg::ST_RUN) && in_valid && restart &&
                      !restart_done_reg && !s1_valid_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            o2pc_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == o2pc_pkg::CLR_LAST)
                begin
                    state_next = o2pc_pkg::ST_RUN;
                end
            end
            o2pc_pkg::ST_RUN:
            begin
                if (clear_start)
                begin
                    state_next = o2pc_pkg::ST_CLEAR;
                end
                else if (in_fire && (mode_reg == o2pc_pkg::MODE_DECOMPRESS) && d_acc_hit)
                begin
                    state_next = o2pc_pkg::ST_DRUN;
                end
            end
            o2pc_pkg::ST_DRUN:
            begin
                if (out_load_ok && !d_run_hit)
                begin
                    state_next = o2pc_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = o2pc_pkg::ST_RUN;
            end
        endcase
    end

    // datapath and memory port control
    always_comb
    begin
        ctx_old_next      = ctx_old_reg;
        ctx_new_next      = ctx_new_reg;
        gp_next           = gp_reg;
        mask_next         = mask_reg;
        cnt_next          = cnt_reg;
        awaiting_next     = awaiting_reg;
        lit_q_next        = lit_q_reg;
        d_last_next       = d_last_reg;
        mode_next         = mode_reg;
        clr_cnt_next      = clr_cnt_reg;
        restart_done_next = restart_done_reg;

        s1_valid_next     = 1'b0;
        s1_byte_next      = s1_byte_reg;
        s1_addr_next      = s1_addr_reg;
        s1_restart_next   = s1_restart_reg;
        s1_last_next      = s1_last_reg;

        em_busy_next      = em_busy_reg;
        em_mask_next      = em_mask_reg;
        em_lit_next       = em_lit_reg;
        em_cnt_next       = em_cnt_reg;
        em_idx_next       = em_idx_reg;

        out_load          = 1'b0;
        out_byte_next     = out_byte_reg;
        out_mask_next     = out_mask_reg;
        out_end_next      = out_end_reg;

        ram_re            = 1'b0;
        ram_raddr         = {ctx_old_reg, ctx_new_reg};
        ram_we            = 1'b0;
        ram_waddr         = clr_cnt_reg;
        ram_wdata         = 8'd0;

        // clearing pass, one entry per cycle
        if (state_reg == o2pc_pkg::ST_CLEAR)
        begin
            ram_we       = 1'b1;
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == o2pc_pkg::CLR_LAST)
            begin
                restart_done_next = 1'b1;
            end
        end

        // drain mask then literals of a finished group
        if (em_busy_reg && out_load_ok)
        begin
            out_load      = 1'b1;
            out_byte_next = (em_idx_reg == 4'd0) ? em_mask_reg : em_lit_reg[em_sel];
            out_mask_next = (em_idx_reg == 4'd0);
            out_end_next  = (em_idx_reg == em_cnt_reg);
            em_idx_next   = em_idx_reg + 4'd1;
            if (em_idx_reg == em_cnt_reg)
            begin
                em_busy_next = 1'b0;
            end
        end

        // compress check stage: mask bit on hit, table write and literal on miss
        if (s1_valid_reg)
        begin
            gp_next    = c_gp_after;
            mask_next  = c_mask_after;
            cnt_next   = c_cnt_after;
            lit_q_next = c_lit_after;
            if (s1_restart_reg)
            begin
                awaiting_next = 1'b1;
            end
            if (!c_hit)
            begin
                ram_we    = 1'b1;
                ram_waddr = s1_addr_reg;
                ram_wdata = s1_byte_reg;
            end
            if (c_done)
            begin
                em_busy_next = 1'b1;
                em_idx_next  = 4'd0;
                em_mask_next = c_mask_after;
                em_cnt_next  = c_cnt_after;
                em_lit_next  = c_lit_after;
            end
            if (c_done || s1_last_reg)
            begin
                gp_next       = 4'd0;
                mask_next     = 8'd0;
                cnt_next      = 4'd0;
                awaiting_next = 1'b1;
            end
        end

        // new request
        if (in_fire)
        begin
            restart_done_next = 1'b0;
            if (mode_reg == o2pc_pkg::MODE_COMPRESS)
            begin
                ram_re          = 1'b1;
                ram_raddr       = restart ? '0 : {ctx_old_reg, ctx_new_reg};
                ctx_old_next    = restart ? 8'd0 : ctx_new_reg;
                ctx_new_next    = data_byte;
                s1_valid_next   = 1'b1;
                s1_byte_next    = data_byte;
                s1_addr_next    = ram_raddr;
                s1_restart_next = restart;
                s1_last_next    = last_byte;
            end
            else
            begin
                gp_next       = d_acc_gp;
                mask_next     = d_acc_mask;
                cnt_next      = 4'd0;
                awaiting_next = 1'b0;
                ctx_old_next  = d_acc_old;
                ctx_new_next  = d_acc_new;
                // literal: write table and show it
                if (!d_is_mask)
                begin
                    ram_we        = 1'b1;
                    ram_waddr     = {d_base_old, d_base_new};
                    ram_wdata     = data_byte;
                    out_load      = 1'b1;
                    out_byte_next = data_byte;
                    out_mask_next = 1'b0;
                    out_end_next  = !d_acc_hit;
                end
                if (d_acc_hit)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = {d_acc_old, d_acc_new};
                    d_last_next = last_byte;
                end
                else if (d_acc_gp[3] || last_byte)
                begin
                    gp_next       = 4'd0;
                    mask_next     = 8'd0;
                    awaiting_next = 1'b1;
                end
            end
        end

        // decompress run of predicted bytes
        if ((state_reg == o2pc_pkg::ST_DRUN) && out_load_ok)
        begin
            out_load      = 1'b1;
            out_byte_next = ram_q_reg;
            out_mask_next = 1'b0;
            out_end_next  = !d_run_hit;
            ctx_old_next  = ctx_new_reg;
            ctx_new_next  = ram_q_reg;
            gp_next       = d_run_gp;
            if (d_run_hit)
            begin
                ram_re    = 1'b1;
                ram_raddr = {ctx_new_reg, ram_q_reg};
            end
            else if (d_run_gp[3] || d_last_reg)
            begin
                gp_next       = 4'd0;
                mask_next     = 8'd0;
                cnt_next      = 4'd0;
                awaiting_next = 1'b1;
            end
        end

        // mode write resets the group
        if (cfg_we)
        begin
            mode_next     = cfg_wdata;
            gp_next       = 4'd0;
            mask_next     = 8'd0;
            cnt_next      = 4'd0;
            awaiting_next = 1'b1;
        end

        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // table memory with write-to-read bypass
    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            pred_mem[ram_waddr] <= ram_wdata;
        end
        if (ram_re)
        begin
            if (ram_we && (ram_waddr == ram_raddr))
            begin
                ram_q_reg <= ram_wdata;
            end
            else
            begin
                ram_q_reg <= pred_mem[ram_raddr];
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= o2pc_pkg::ST_CLEAR;
            clr_cnt_reg      <= '0;
            restart_done_reg <= 1'b0;
            mode_reg         <= o2pc_pkg::MODE_COMPRESS;
            ctx_old_reg      <= 8'd0;
            ctx_new_reg      <= 8'd0;
            gp_reg           <= 4'd0;
            mask_reg         <= 8'd0;
            cnt_reg          <= 4'd0;
            awaiting_reg     <= 1'b1;
            s1_valid_reg     <= 1'b0;
            em_busy_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            restart_done_reg <= restart_done_next;
            mode_reg         <= mode_next;
            ctx_old_reg      <= ctx_old_next;
            ctx_new_reg      <= ctx_new_next;
            gp_reg           <= gp_next;
            mask_reg         <= mask_next;
            cnt_reg          <= cnt_next;
            awaiting_reg     <= awaiting_next;
            s1_valid_reg     <= s1_valid_next;
            em_busy_reg      <= em_busy_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lit_q_reg      <= lit_q_next;
        d_last_reg     <= d_last_next;
        s1_byte_reg    <= s1_byte_next;
        s1_addr_reg    <= s1_addr_next;
        s1_restart_reg <= s1_restart_next;
        s1_last_reg    <= s1_last_next;
        em_mask_reg    <= em_mask_next;
        em_lit_reg     <= em_lit_next;
        em_cnt_reg     <= em_cnt_next;
        em_idx_reg     <= em_idx_next;
        out_byte_reg   <= out_byte_next;
        out_mask_reg   <= out_mask_next;
        out_end_reg    <= out_end_next;
    end

    // result port
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign is_mask   = out_mask_reg;
    assign run_end   = out_end_reg;

endmodule
`default_nettype wire
